### rtl/core/deadline_job_sequencer_macros.svh
// Assertion macros shared by the deadline job sequencer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef DEADLINE_JOB_SEQUENCER_MACROS_SVH
`define DEADLINE_JOB_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DJS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DJS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/djs_pkg.sv
// Shared types and constants of the deadline job sequencer.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none

package djs_pkg;

  localparam int ID_W     = 8;
  localparam int DL_W     = 8;
  localparam int PROFIT_W = 16;
  localparam int SLOT_W   = 4;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [DL_W-1:0]     deadline;
    logic [PROFIT_W-1:0] profit;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  typedef struct packed {
    logic load;
    logic sched_init;
    logic scan_step;
    logic pick;
    logic walk_step;
    logic out_init;
    logic out_skip;
    logic out_emit;
    logic emit_none;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic walk_done;
    logic all_ranked;
    logic any_taken;
    logic out_done;
    logic cur_taken;
    logic is_last;
  } stat_t;

endpackage

`default_nettype wire

### rtl/core/djs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; instantiated by the datapath for every store.
`default_nettype none

module djs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/djs_ctrl.sv
// Sequencing state machine of the deadline job sequencer.
// Depends on djs_pkg; drives the datapath through djs_pkg::cmd_t commands.
`default_nettype none

module djs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          in_last_job,
  input  wire djs_pkg::stat_t st,
  output logic               busy,
  output djs_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_OUTRD = 3'd4;
  localparam logic [2:0] S_OUTEM = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_last_job) begin
            cmd.sched_init = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (st.walk_done) begin
          if (st.all_ranked) begin
            cmd.out_init = 1'b1;
            state_nxt    = S_OUTRD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_OUTRD: begin
        if (!st.any_taken) begin
          cmd.emit_none = 1'b1;
          cmd.finish    = 1'b1;
          state_nxt     = S_IDLE;
        end else if (st.out_done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else if (st.cur_taken) begin
          state_nxt = S_OUTEM;
        end else begin
          cmd.out_skip = 1'b1;
        end
      end
      S_OUTEM: begin
        cmd.out_emit = 1'b1;
        if (st.is_last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_OUTRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

### rtl/core/djs_dp.sv
// Datapath of the deadline job sequencer: job store, ranking scan, slot walk
// and result registers. Depends on djs_pkg, djs_ram and the assertion macros.
`default_nettype none
`include "deadline_job_sequencer_macros.svh"

module djs_dp #(
  parameter int MAX_JOBS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [djs_pkg::ID_W-1:0]      in_job_id,
  input  wire logic [djs_pkg::DL_W-1:0]      in_deadline,
  input  wire logic [djs_pkg::PROFIT_W-1:0]  in_profit,
  input  wire djs_pkg::cmd_t                 cmd,
  output djs_pkg::stat_t                     st,
  output logic                               out_valid,
  output logic [djs_pkg::ID_W-1:0]           out_sched_id,
  output logic [djs_pkg::SLOT_W-1:0]         out_slot_index,
  output logic                               out_none_scheduled,
  output logic                               out_last_result
);

  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

  logic [CW-1:0]                   load_cnt_r;
  logic [CW-1:0]                   scan_r;
  logic [CW-1:0]                   slot_r;
  logic [CW-1:0]                   rank_r;
  logic [MAX_JOBS-1:0]             used_r;
  logic [MAX_JOBS-1:0]             taken_r;
  logic                            pend_v_r;
  logic [IW-1:0]                   pend_idx_r;
  logic                            best_v_r;
  logic [IW-1:0]                   best_idx_r;
  logic [djs_pkg::PROFIT_W-1:0]    best_profit_r;
  logic [djs_pkg::ID_W-1:0]        best_id_r;
  logic [djs_pkg::DL_W-1:0]        best_dl_r;
  logic                            any_r;
  logic [IW-1:0]                   max_slot_r;
  logic                            out_valid_r;
  logic [djs_pkg::ID_W-1:0]        out_id_r;
  logic [djs_pkg::SLOT_W-1:0]      out_idx_r;
  logic                            out_none_r;
  logic                            out_last_r;

  djs_pkg::job_t                   job_wdata;
  djs_pkg::job_t                   job_rdata;
  logic                            job_we;
  logic [djs_pkg::ID_W-1:0]        slot_rdata;
  logic                            slot_wr_en;
  logic                            scan_issue;
  logic                            better;
  logic [CW-1:0]                   slot_m1;
  logic [IW-1:0]                   walk_idx;
  logic [IW-1:0]                   scan_idx;
  logic [CW-1:0]                   lim;

  assign scan_idx   = scan_r[IW-1:0];
  assign job_we     = cmd.load && (load_cnt_r < CW'(MAX_JOBS));
  assign job_wdata  = '{id: in_job_id, deadline: in_deadline, profit: in_profit};
  assign scan_issue = cmd.scan_step && (scan_r != load_cnt_r);
  assign better     = pend_v_r && !used_r[pend_idx_r] &&
                      (!best_v_r || (job_rdata.profit > best_profit_r));
  assign slot_m1    = slot_r - CW'(1);
  assign walk_idx   = slot_m1[IW-1:0];
  assign slot_wr_en = cmd.walk_step && (slot_r != '0) && !taken_r[walk_idx];
  assign lim        = (best_dl_r > djs_pkg::DL_W'(load_cnt_r)) ? load_cnt_r
                                                                : CW'(best_dl_r);

  djs_ram #(
    .WIDTH (djs_pkg::JOB_W),
    .DEPTH (MAX_JOBS),
    .AW    (IW)
  ) u_job_ram (
    .clk   (clk),
    .we    (job_we),
    .waddr (load_cnt_r[IW-1:0]),
    .wdata (job_wdata),
    .raddr (scan_idx),
    .rdata (job_rdata)
  );

  djs_ram #(
    .WIDTH (djs_pkg::ID_W),
    .DEPTH (MAX_JOBS),
    .AW    (IW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_wr_en),
    .waddr (walk_idx),
    .wdata (best_id_r),
    .raddr (scan_idx),
    .rdata (slot_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r  <= '0;
      taken_r     <= '0;
      used_r      <= '0;
      any_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      best_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_emit || cmd.emit_none;
      if (job_we) begin
        load_cnt_r <= load_cnt_r + CW'(1);
      end
      if (cmd.sched_init) begin
        used_r   <= '0;
        pend_v_r <= 1'b0;
        best_v_r <= 1'b0;
      end else begin
        pend_v_r <= scan_issue;
        if (better) begin
          best_v_r <= 1'b1;
        end
        if (cmd.pick) begin
          used_r[best_idx_r] <= 1'b1;
          best_v_r           <= 1'b0;
        end
      end
      if (slot_wr_en) begin
        taken_r[walk_idx] <= 1'b1;
        any_r             <= 1'b1;
      end
      if (cmd.finish) begin
        load_cnt_r <= '0;
        taken_r    <= '0;
        any_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sched_init) begin
      scan_r <= '0;
      rank_r <= '0;
    end else if (cmd.pick) begin
      scan_r <= '0;
      rank_r <= rank_r + CW'(1);
    end else if (cmd.out_init) begin
      scan_r <= '0;
    end else if (scan_issue || cmd.out_skip || cmd.out_emit) begin
      scan_r <= scan_r + CW'(1);
    end
    pend_idx_r <= scan_idx;
    if (better) begin
      best_idx_r    <= pend_idx_r;
      best_profit_r <= job_rdata.profit;
      best_id_r     <= job_rdata.id;
      best_dl_r     <= job_rdata.deadline;
    end
    if (cmd.pick) begin
      slot_r <= lim;
    end else if (cmd.walk_step && !slot_wr_en && (slot_r != '0)) begin
      slot_r <= slot_m1;
    end
    if (slot_wr_en && (!any_r || (walk_idx > max_slot_r))) begin
      max_slot_r <= walk_idx;
    end
    if (cmd.emit_none) begin
      out_id_r   <= '0;
      out_idx_r  <= '0;
      out_none_r <= 1'b1;
      out_last_r <= 1'b1;
    end else if (cmd.out_emit) begin
      out_id_r   <= slot_rdata;
      out_idx_r  <= djs_pkg::SLOT_W'(scan_r);
      out_none_r <= 1'b0;
      out_last_r <= (scan_idx == max_slot_r);
    end
  end

  always_comb begin
    st            = '0;
    st.scan_done  = (scan_r == load_cnt_r) && !pend_v_r;
    st.walk_done  = (slot_r == '0) || !taken_r[walk_idx];
    st.all_ranked = (rank_r == load_cnt_r);
    st.any_taken  = any_r;
    st.out_done   = (scan_r == load_cnt_r);
    st.cur_taken  = taken_r[scan_idx];
    st.is_last    = (scan_idx == max_slot_r);
  end

  assign out_valid          = out_valid_r;
  assign out_sched_id       = out_id_r;
  assign out_slot_index     = out_idx_r;
  assign out_none_scheduled = out_none_r;
  assign out_last_result    = out_last_r;

  `DJS_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, load_cnt_r <= CW'(MAX_JOBS), "job count overflow")
  `DJS_ASSERT_IMP(a_pick_found, clk, rst_n, cmd.pick, best_v_r, "pick without a ranked job")
  `DJS_ASSERT_IMP(a_emit_taken, clk, rst_n, cmd.out_emit, taken_r[scan_idx], "emit of free slot")
  `DJS_ASSERT_NXT(a_take_marks, clk, rst_n, slot_wr_en, any_r, "slot taken but not recorded")

endmodule

`default_nettype wire

### rtl/core/deadline_job_sequencer.sv
// Top level of the deadline job sequencer: controller plus datapath.
// Depends on djs_pkg, djs_ctrl, djs_dp and the assertion macros.
//
// Usage: jobs are loaded one per transfer on the in_ channel (start high
// while busy is low). Each job carries an id, a deadline and a profit;
// in_last_job marks the final job of a set. Loading raises no result.
// Jobs beyond MAX_JOBS are dropped. After the last job, busy stays high
// while the jobs are ranked by profit (highest first, load order on ties)
// and each takes the latest free slot below min(deadline, job count).
// Each rank takes a scan over the job RAM, a pick and a slot walk down
// past the taken slots. The output pass reads the slots in order up to
// the highest scheduled one, emitting each scheduled job and skipping
// each free slot, or gives a single result for an empty schedule.
// Results appear on the out_ channel in slot order, each for one cycle with
// out_valid high; the receiver cannot stall them. An empty schedule gives a
// single result with out_none_scheduled set. The final result carries
// out_last_result. Synchronous reset empties the job set and slot map.
`default_nettype none
`include "deadline_job_sequencer_macros.svh"

module deadline_job_sequencer #(
  parameter int MAX_JOBS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [djs_pkg::ID_W-1:0]      in_job_id,
  input  wire logic [djs_pkg::DL_W-1:0]      in_deadline,
  input  wire logic [djs_pkg::PROFIT_W-1:0]  in_profit,
  input  wire logic                          in_last_job,
  output logic                               out_valid,
  output logic [djs_pkg::ID_W-1:0]           out_sched_id,
  output logic [djs_pkg::SLOT_W-1:0]         out_slot_index,
  output logic                               out_none_scheduled,
  output logic                               out_last_result
);

  djs_pkg::cmd_t  cmd;
  djs_pkg::stat_t st;
  logic           none_valid;

  djs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_last_job (in_last_job),
    .st          (st),
    .busy        (busy),
    .cmd         (cmd)
  );

  djs_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_job_id          (in_job_id),
    .in_deadline        (in_deadline),
    .in_profit          (in_profit),
    .cmd                (cmd),
    .st                 (st),
    .out_valid          (out_valid),
    .out_sched_id       (out_sched_id),
    .out_slot_index     (out_slot_index),
    .out_none_scheduled (out_none_scheduled),
    .out_last_result    (out_last_result)
  );

  assign none_valid = out_valid && out_none_scheduled;

  `DJS_ASSERT_IMP(a_none_is_last, clk, rst_n, none_valid, out_last_result, "empty result not last")

endmodule

`default_nettype wire
